// ----- design/obm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obm_pkg: shared types and constants for the fast/slow order book merge
// Holds default sizes, the controller state type and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package obm_pkg;

    localparam int SYMBOLS_DEF    = 16;
    localparam int MAX_LEVELS_DEF = 24;
    localparam int FAST_MAX_DEF   = 8;
    localparam int PRICE_W        = 48;
    localparam int SIZE_W         = 48;
    localparam int ORDERS_W       = 20;
    localparam int LEVEL_W        = PRICE_W + SIZE_W + ORDERS_W;
    localparam int CFG_DATA_W     = 4;
    localparam int CFG_IDX_W      = 1;
    localparam logic [3:0] DEPTH_LIMIT_RST = 4'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MERGE_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT  = 1'b1;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE_RD,
        ST_STORE_WR,
        ST_EMIT_SEL,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT,
        ST_EMPTY
    } obm_state_t;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_FAST,
        SRC_SLOW
    } obm_src_t;

    typedef struct packed {
        logic     clear_ptr;
        logic     set_side;
        logic     side;
        logic     store_rd;
        logic     store_wr;
        logic     commit;
        obm_src_t src;
        logic     emit_rd;
        logic     emit_out;
        logic     adv_ptr;
        logic     last;
        logic     empty_out;
        logic     clear_in;
    } obm_cmd_t;

    typedef struct packed {
        logic is_fast;
        logic has_fast;
        logic has_slow;
        logic store_done;
        logic in_done;
        logic fast_done;
        logic slow_done;
        logic fast_empty;
        logic take;
        logic any_emitted;
    } obm_sts_t;

endpackage
`default_nettype wire

// ----- design/obm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module obm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/obm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obm_ctrl: controller for the order book merge
// Sequences snapshot storage and merged book emission over the datapath.
// ----------------------------------------------------------------------------
module obm_ctrl
    import obm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     snapshot_end,
    input  wire logic     merge_en,
    input  wire obm_sts_t sts,
    output obm_cmd_t      cmd,
    output logic          busy
);

    obm_state_t state_reg, state_next;
    logic       side_reg, side_next;
    obm_src_t   src_reg, src_next;
    logic       merge_reg, merge_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= SIDE_BID;
            src_reg   <= SRC_IN;
            merge_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            src_reg   <= src_next;
            merge_reg <= merge_next;
        end
    end

    // pick source for the current side; returns SRC_IN when merging is off
    function automatic obm_src_t first_src(input obm_sts_t s, input logic mg);
        obm_src_t r;
        r = SRC_IN;
        if (mg)
        begin
            if (s.has_fast && !(s.has_slow && s.fast_empty))
            begin
                r = SRC_FAST;
            end
            else
            begin
                r = SRC_SLOW;
            end
        end
        return r;
    endfunction

    logic cur_done;
    always_comb
    begin
        unique case (src_reg)
            SRC_FAST: cur_done = sts.fast_done;
            SRC_SLOW: cur_done = sts.slow_done || !sts.has_slow;
            default:  cur_done = sts.in_done;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        src_next   = src_reg;
        merge_next = merge_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && snapshot_end)
                begin
                    merge_next = merge_en;
                    side_next  = SIDE_BID;
                    state_next = merge_en ? ST_STORE_RD : ST_EMIT_RD;
                    src_next   = SRC_IN;
                end
            end
            ST_STORE_RD:  state_next = ST_STORE_WR;
            ST_STORE_WR:
            begin
                if (sts.store_done)
                begin
                    if (side_reg == SIDE_ASK)
                    begin
                        side_next  = SIDE_BID;
                        state_next = ST_EMIT_SEL;
                    end
                    else
                    begin
                        side_next  = SIDE_ASK;
                        state_next = ST_STORE_RD;
                    end
                end
                else
                begin
                    state_next = ST_STORE_RD;
                end
            end
            ST_EMIT_SEL:
            begin
                src_next   = first_src(sts, 1'b1);
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                if (cur_done)
                begin
                    if (src_reg == SRC_FAST && sts.has_slow)
                    begin
                        src_next = SRC_SLOW;
                    end
                    else if (side_reg == SIDE_BID)
                    begin
                        side_next = SIDE_ASK;
                        if (merge_reg)
                        begin
                            state_next = ST_EMIT_SEL;
                        end
                        else
                        begin
                            src_next = SRC_IN;
                        end
                    end
                    else
                    begin
                        state_next = ST_EMPTY;
                    end
                end
                else
                begin
                    state_next = ST_EMIT_WAIT;
                end
            end
            ST_EMIT_WAIT: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:  state_next = ST_EMIT_RD;
            ST_EMPTY:     state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.side = side_reg;
        cmd.src  = src_reg;
        busy     = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.clear_ptr = start && snapshot_end;
                cmd.set_side  = 1'b1;
            end
            ST_STORE_RD: cmd.store_rd = 1'b1;
            ST_STORE_WR:
            begin
                cmd.store_wr = 1'b1;
                if (sts.store_done)
                begin
                    cmd.clear_ptr = 1'b1;
                    cmd.commit    = (side_reg == SIDE_ASK);
                end
            end
            ST_EMIT_SEL: ;
            ST_EMIT_RD:
            begin
                if (cur_done)
                begin
                    cmd.clear_ptr = 1'b1;
                end
                else
                begin
                    cmd.emit_rd = 1'b1;
                end
            end
            ST_EMIT_WAIT: ;
            ST_EMIT_OUT:
            begin
                cmd.emit_out = 1'b1;
                cmd.adv_ptr  = 1'b1;
            end
            ST_EMPTY:
            begin
                cmd.empty_out = 1'b1;
                cmd.clear_in  = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/obm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obm_dp: datapath for the order book merge
// Collector, fast and slow caches, counts and the output register.
// ----------------------------------------------------------------------------
module obm_dp
    import obm_pkg::*;
#(
    parameter int SYMBOLS    = SYMBOLS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int FAST_MAX   = FAST_MAX_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [3:0]          symbol_index,
    input  wire logic                level_valid,
    input  wire logic                level_side,
    input  wire logic [PRICE_W-1:0]  level_price,
    input  wire logic [SIZE_W-1:0]   level_size,
    input  wire logic [ORDERS_W-1:0] level_orders,
    input  wire logic                merge_en,
    input  wire logic [3:0]          depth_limit,
    input  wire obm_cmd_t            cmd,
    output obm_sts_t                 sts,
    output logic                     result_valid,
    output logic                     out_valid_level,
    output logic                     out_side,
    output logic [PRICE_W-1:0]       out_price,
    output logic [SIZE_W-1:0]        out_size,
    output logic [ORDERS_W-1:0]      out_orders,
    output logic                     out_last
);

    localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int LVL_W   = $clog2(MAX_LEVELS + 1);
    localparam int LI_W    = $clog2(MAX_LEVELS);
    localparam int FC_W    = $clog2(FAST_MAX + 1);
    localparam int FI_W    = (FAST_MAX > 1) ? $clog2(FAST_MAX) : 1;
    localparam int IN_D    = 2 * MAX_LEVELS;
    localparam int FAST_D  = SYMBOLS * 2 * FAST_MAX;
    localparam int SLOW_D  = SYMBOLS * 2 * MAX_LEVELS;
    localparam int IN_AW   = $clog2(IN_D);
    localparam int FAST_AW = $clog2(FAST_D);
    localparam int SLOW_AW = $clog2(SLOW_D);
    localparam int SLOT_W  = SYM_W + 1;

    logic [LVL_W-1:0] in_cnt_reg [2];
    logic [FC_W-1:0]  fast_cnt_reg [2*SYMBOLS];
    logic [LVL_W-1:0] slow_cnt_reg [2*SYMBOLS];
    logic [1:0]       present_reg [SYMBOLS];
    logic [SYM_W-1:0] sym_reg;
    logic [LVL_W-1:0] ptr_reg;
    logic             is_fast_reg;
    logic             any_reg;
    logic [PRICE_W-1:0] cutoff_reg;
    logic             rd_src_fast_reg;

    // fold the symbol into range through a constant table
    logic [SYM_W-1:0] sym_in;
    always_comb
    begin
        sym_in = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (symbol_index == 4'(i))
            begin
                sym_in = SYM_W'(i % SYMBOLS);
            end
        end
    end

    logic             accept;
    assign accept = start && !busy;

    logic [SLOT_W-1:0] slot;
    assign slot = {sym_reg, cmd.side};

    // collector RAM
    logic              in_we;
    logic [IN_AW-1:0]  in_waddr, in_raddr;
    logic [LEVEL_W-1:0] in_rdata;
    assign in_we    = accept && level_valid && (in_cnt_reg[level_side] < LVL_W'(MAX_LEVELS));
    assign in_waddr = IN_AW'(level_side * MAX_LEVELS) + IN_AW'(in_cnt_reg[level_side]);
    assign in_raddr = IN_AW'(cmd.side * MAX_LEVELS) + IN_AW'(ptr_reg);

    obm_ram #(.WIDTH(LEVEL_W), .DEPTH(IN_D)) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata ({level_price, level_size, level_orders}),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    logic [LVL_W-1:0] in_side_cnt;
    logic [FC_W-1:0]  fast_store_cnt;
    assign in_side_cnt    = in_cnt_reg[cmd.side];
    assign fast_store_cnt = (in_side_cnt > LVL_W'(FAST_MAX)) ? FC_W'(FAST_MAX)
                                                             : FC_W'(in_side_cnt);

    // fast and slow cache RAMs
    logic               f_we, s_we;
    logic [FAST_AW-1:0] f_addr_w, f_addr_r;
    logic [SLOW_AW-1:0] s_addr_w, s_addr_r;
    logic [LEVEL_W-1:0] f_rdata, s_rdata;
    logic [LVL_W-1:0]   wr_ptr_reg;

    assign f_we     = cmd.store_wr && is_fast_reg && !sts.store_done;
    assign s_we     = cmd.store_wr && !is_fast_reg && !sts.store_done;
    assign f_addr_w = FAST_AW'(slot * FAST_MAX) + FAST_AW'(wr_ptr_reg);
    assign s_addr_w = SLOW_AW'(slot * MAX_LEVELS) + SLOW_AW'(wr_ptr_reg);

    // cutoff is taken from the fast read port during the fast walk
    logic [FI_W-1:0] f_idx;
    assign f_idx    = FI_W'(ptr_reg);
    assign f_addr_r = FAST_AW'(slot * FAST_MAX) + FAST_AW'(f_idx);
    assign s_addr_r = SLOW_AW'(slot * MAX_LEVELS) + SLOW_AW'(LI_W'(ptr_reg));

    obm_ram #(.WIDTH(LEVEL_W), .DEPTH(FAST_D)) u_fast_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_addr_w),
        .wdata (in_rdata),
        .raddr (f_addr_r),
        .rdata (f_rdata)
    );

    obm_ram #(.WIDTH(LEVEL_W), .DEPTH(SLOW_D)) u_slow_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_addr_w),
        .wdata (in_rdata),
        .raddr (s_addr_r),
        .rdata (s_rdata)
    );

    // status
    logic [LVL_W-1:0] store_lim;
    assign store_lim = is_fast_reg ? LVL_W'(fast_store_cnt) : in_side_cnt;

    logic [FC_W-1:0]  fcnt;
    logic [LVL_W-1:0] scnt;
    assign fcnt = fast_cnt_reg[slot];
    assign scnt = slow_cnt_reg[slot];

    logic [LVL_W-1:0] depth;
    logic [3:0]       lim;
    assign depth = (in_cnt_reg[0] > in_cnt_reg[1]) ? in_cnt_reg[0] : in_cnt_reg[1];
    assign lim   = (depth_limit > 4'(FAST_MAX)) ? 4'(FAST_MAX) : depth_limit;

    logic [PRICE_W-1:0] rd_price;
    assign rd_price = s_rdata[LEVEL_W-1 -: PRICE_W];

    logic filtered;
    assign filtered = present_reg[sym_reg][0] && (fcnt != '0);

    always_comb
    begin
        sts.is_fast     = is_fast_reg;
        sts.has_fast    = present_reg[sym_reg][0];
        sts.has_slow    = present_reg[sym_reg][1];
        sts.store_done  = (wr_ptr_reg >= store_lim);
        sts.in_done     = (ptr_reg >= in_side_cnt);
        sts.fast_done   = (ptr_reg >= LVL_W'(fcnt));
        sts.slow_done   = (ptr_reg >= scnt);
        sts.fast_empty  = (fcnt == '0);
        sts.any_emitted = any_reg;
        if (!filtered)
        begin
            sts.take = 1'b1;
        end
        else if (cmd.side == SIDE_BID)
        begin
            sts.take = rd_price < cutoff_reg;
        end
        else
        begin
            sts.take = rd_price > cutoff_reg;
        end
    end

    // pointers, counts and caches bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg[0] <= '0;
            in_cnt_reg[1] <= '0;
            for (int i = 0; i < 2 * SYMBOLS; i++)
            begin
                fast_cnt_reg[i] <= '0;
                slow_cnt_reg[i] <= '0;
            end
            for (int i = 0; i < SYMBOLS; i++)
            begin
                present_reg[i] <= '0;
            end
            sym_reg         <= '0;
            ptr_reg         <= '0;
            wr_ptr_reg      <= '0;
            is_fast_reg     <= 1'b0;
            any_reg         <= 1'b0;
            rd_src_fast_reg <= 1'b0;
        end
        else
        begin
            if (in_we)
            begin
                in_cnt_reg[level_side] <= in_cnt_reg[level_side] + 1'b1;
            end
            if (accept && cmd.clear_ptr)
            begin
                sym_reg     <= sym_in;
                is_fast_reg <= (depth + LVL_W'(in_we && (in_cnt_reg[level_side] + 1'b1 > depth)))
                               <= LVL_W'(lim);
                any_reg     <= 1'b0;
            end
            if (cmd.clear_ptr)
            begin
                ptr_reg    <= '0;
                wr_ptr_reg <= '0;
            end
            if (cmd.store_rd)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.store_wr && !sts.store_done)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd.store_wr && sts.store_done)
            begin
                if (is_fast_reg)
                begin
                    fast_cnt_reg[slot] <= fast_store_cnt;
                end
                else
                begin
                    slow_cnt_reg[slot] <= in_side_cnt;
                end
            end
            if (cmd.commit)
            begin
                present_reg[sym_reg] <= present_reg[sym_reg] |
                                        (is_fast_reg ? 2'b01 : 2'b10);
            end
            if (cmd.adv_ptr)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.emit_rd)
            begin
                rd_src_fast_reg <= (cmd.src == SRC_FAST);
            end
            if (cmd.emit_out && (cmd.src != SRC_SLOW || sts.take))
            begin
                any_reg <= 1'b1;
            end
            if (cmd.clear_in)
            begin
                in_cnt_reg[0] <= '0;
                in_cnt_reg[1] <= '0;
            end
        end
    end

    // last fast price per side is captured as the walk passes it
    always_ff @(posedge clk)
    begin
        if (cmd.emit_out && cmd.src == SRC_FAST)
        begin
            cutoff_reg <= f_rdata[LEVEL_W-1 -: PRICE_W];
        end
    end

    // output register: one pending level, released on the next emit or end
    logic               pend_reg;
    logic               pend_side_reg;
    logic [LEVEL_W-1:0] pend_lvl_reg;
    logic [LEVEL_W-1:0] sel_lvl;
    logic               emit_now;

    always_comb
    begin
        unique case (cmd.src)
            SRC_FAST: sel_lvl = f_rdata;
            SRC_SLOW: sel_lvl = s_rdata;
            default:  sel_lvl = in_rdata;
        endcase
    end
    assign emit_now = cmd.emit_out && (cmd.src != SRC_SLOW || sts.take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= (emit_now && pend_reg) || cmd.empty_out;
            if (emit_now)
            begin
                pend_reg <= 1'b1;
            end
            else if (cmd.empty_out)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            pend_side_reg <= cmd.side;
            pend_lvl_reg  <= sel_lvl;
        end
        if ((emit_now && pend_reg) || cmd.empty_out)
        begin
            out_valid_level <= pend_reg;
            out_side        <= pend_reg ? pend_side_reg : 1'b0;
            out_price       <= pend_reg ? pend_lvl_reg[LEVEL_W-1 -: PRICE_W] : '0;
            out_size        <= pend_reg ? pend_lvl_reg[ORDERS_W +: SIZE_W] : '0;
            out_orders      <= pend_reg ? pend_lvl_reg[ORDERS_W-1:0] : '0;
            out_last        <= cmd.empty_out;
        end
    end

    logic unused_ok;
    assign unused_ok = rd_src_fast_reg ^ merge_en ^ sts.any_emitted;

endmodule
`default_nettype wire

// ----- design/order_book_fast_slow_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// order_book_fast_slow_merge: fast/slow order book merge
// Collects book snapshot levels and emits merged books per symbol.
// ----------------------------------------------------------------------------
// Usage:
//   A level is taken at a clock edge with start high and busy low. Levels
//   without snapshot_end are only collected and produce nothing.
//   The item with snapshot_end sets busy. With merging on, the snapshot is
//   copied level by level into the symbol's fast or slow cache through a
//   read state and a write state, then the merged book is walked, each
//   candidate level passing a read, a wait and an output state; with merging
//   off the collected levels are walked the same way without the copy.
//   Each result appears for one cycle with result_valid high; out_last
//   marks the final one. An empty book gives one result with
//   out_valid_level low. A level is held back until the next one is emitted
//   or the walk ends; busy falls in the cycle that shows the last result.
//   Reset clears counts and presence flags; cache contents are not cleared.
//   Results cannot be held off by the receiver. Configuration writes take
//   effect at once; the user must make them while idle, which is not enforced.
// ----------------------------------------------------------------------------
module order_book_fast_slow_merge
    import obm_pkg::*;
#(
    parameter int SYMBOLS    = SYMBOLS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int FAST_MAX   = FAST_MAX_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [3:0]            symbol_index,
    input  wire logic                  level_valid,
    input  wire logic                  level_side,
    input  wire logic [PRICE_W-1:0]    level_price,
    input  wire logic [SIZE_W-1:0]     level_size,
    input  wire logic [ORDERS_W-1:0]   level_orders,
    input  wire logic                  snapshot_end,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       result_valid,
    output logic                       out_valid_level,
    output logic                       out_side,
    output logic [PRICE_W-1:0]         out_price,
    output logic [SIZE_W-1:0]          out_size,
    output logic [ORDERS_W-1:0]        out_orders,
    output logic                       out_last
);

    logic       merge_en_reg;
    logic [3:0] depth_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_en_reg    <= 1'b0;
            depth_limit_reg <= DEPTH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MERGE_ENABLE: merge_en_reg    <= cfg_data[0];
                REG_DEPTH_LIMIT:  depth_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    obm_cmd_t cmd;
    obm_sts_t sts;

    obm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .snapshot_end (snapshot_end),
        .merge_en     (merge_en_reg),
        .sts          (sts),
        .cmd          (cmd),
        .busy         (busy)
    );

    obm_dp #(
        .SYMBOLS    (SYMBOLS),
        .MAX_LEVELS (MAX_LEVELS),
        .FAST_MAX   (FAST_MAX)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .symbol_index    (symbol_index),
        .level_valid     (level_valid),
        .level_side      (level_side),
        .level_price     (level_price),
        .level_size      (level_size),
        .level_orders    (level_orders),
        .merge_en        (merge_en_reg),
        .depth_limit     (depth_limit_reg),
        .cmd             (cmd),
        .sts             (sts),
        .result_valid    (result_valid),
        .out_valid_level (out_valid_level),
        .out_side        (out_side),
        .out_price       (out_price),
        .out_size        (out_size),
        .out_orders      (out_orders),
        .out_last        (out_last)
    );

endmodule
`default_nettype wire

// ----- design/obm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obm_checker: port-level checks for the order book merge
// Watches busy and the result strobe over time.
// ----------------------------------------------------------------------------
module obm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic snapshot_end,
    input wire logic result_valid,
    input wire logic out_last
);

    a_end_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && snapshot_end |=> busy)
        else $error("end transfer did not raise busy");

    a_level_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !snapshot_end |=> !busy)
        else $error("plain level raised busy");

    a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_last |-> busy)
        else $error("result outside busy");

    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_last |=> !result_valid)
        else $error("result after last");

endmodule

bind order_book_fast_slow_merge obm_checker u_obm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .snapshot_end (snapshot_end),
    .result_valid (result_valid),
    .out_last     (out_last)
);
`default_nettype wire
